// ===== sv/pip_pkg.sv =====
// Shared command codes and item classes for the point-in-polygon block.
package pip_pkg;

  // Input command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Item class after decode
  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_CLEAR,
    OP_NONE
  } op_t;

  localparam int OP_BITS = $bits(op_t);

endpackage

// ===== sv/pip_front.sv =====
// Front end: accepts items, decodes the command and translates query points.
module pip_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_command,
  input  logic [COORD_BITS-1:0]   in_coord_x,
  input  logic [COORD_BITS-1:0]   in_coord_y,
  input  logic [COORD_BITS-1:0]   in_offset_x,
  input  logic [COORD_BITS-1:0]   in_offset_y,
  output logic                    q_valid,
  input  logic                    q_ready,
  output pip_pkg::op_t            q_op,
  output logic [COORD_BITS:0]     q_x,
  output logic [COORD_BITS:0]     q_y
);

  logic                  valid_r;
  logic                  valid_nxt;
  pip_pkg::op_t          op_r;
  pip_pkg::op_t          op_nxt;
  logic [COORD_BITS:0]   x_r;
  logic [COORD_BITS:0]   x_nxt;
  logic [COORD_BITS:0]   y_r;
  logic [COORD_BITS:0]   y_nxt;
  logic                  accept;
  logic signed [COORD_BITS:0] cx_e;
  logic signed [COORD_BITS:0] cy_e;
  logic signed [COORD_BITS:0] ox_e;
  logic signed [COORD_BITS:0] oy_e;

  // Take a new item whenever the holding register is empty or draining
  assign in_ready  = !valid_r || q_ready;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept || (valid_r && !q_ready);

  // Sign-extend the coordinates by one bit
  assign cx_e = {in_coord_x[COORD_BITS-1], in_coord_x};
  assign cy_e = {in_coord_y[COORD_BITS-1], in_coord_y};
  assign ox_e = {in_offset_x[COORD_BITS-1], in_offset_x};
  assign oy_e = {in_offset_y[COORD_BITS-1], in_offset_y};

  // Decode the command and translate a query point
  always_comb begin
    unique case (in_command)
      pip_pkg::CMD_APPEND: op_nxt = pip_pkg::OP_APPEND;
      pip_pkg::CMD_QUERY:  op_nxt = pip_pkg::OP_QUERY;
      pip_pkg::CMD_CLEAR:  op_nxt = pip_pkg::OP_CLEAR;
      default:             op_nxt = pip_pkg::OP_NONE;
    endcase
    if (op_nxt == pip_pkg::OP_QUERY) begin
      x_nxt = cx_e - ox_e;
      y_nxt = cy_e - oy_e;
    end else begin
      x_nxt = cx_e;
      y_nxt = cy_e;
    end
  end

  // Hold the decoded item until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      op_r <= op_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_op    = op_r;
  assign q_x     = x_r;
  assign q_y     = y_r;

endmodule

// ===== sv/pip_queue.sv =====
// Two-entry queue between the front end and the edge walker.
module pip_queue #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam logic [1:0] FULL_CNT = 2'd2;

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic         push;
  logic         pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Advance pointers and store pushed items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/pip_back.sv =====
// Back end: vertex store, edge-walk pipeline and result register.
module pip_back #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  pip_pkg::op_t          q_op,
  input  logic [COORD_BITS:0]   q_x,
  input  logic [COORD_BITS:0]   q_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_inside_res,
  output logic                  out_status
);

  localparam int C   = COORD_BITS;
  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int PW  = 2 * C + 3;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  // Vertex store
  logic [C-1:0] mem_x [MAX_VERTICES];
  logic [C-1:0] mem_y [MAX_VERTICES];
  logic [C-1:0] mem_qx;
  logic [C-1:0] mem_qy;
  logic         we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Control
  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] k_r;
  logic          out_valid_r;
  logic          inside_r;
  logic          status_r;
  logic          out_free;
  logic          pop;
  logic          start_walk;
  logic          rd_en;
  logic          pipe_empty;

  // Query point, one bit wider than a coordinate
  logic signed [C:0] px_r;
  logic signed [C:0] py_r;

  // Pipeline
  logic               s1_v_r;
  logic               s1_first_r;
  logic [C-1:0]       prev_x_r;
  logic [C-1:0]       prev_y_r;
  logic signed [C+1:0] xi_e;
  logic signed [C+1:0] yi_e;
  logic signed [C+1:0] xj_e;
  logic signed [C+1:0] yj_e;
  logic signed [C+1:0] px_e;
  logic signed [C+1:0] py_e;
  logic signed [C+1:0] dy_full;
  logic signed [C+1:0] dxji_full;
  logic signed [C+1:0] dyi;
  logic signed [C+1:0] dxi;
  logic               straddle;
  logic               leftish;
  logic               s2_v_r;
  logic signed [C+1:0] s2_dyi_r;
  logic signed [C:0]   s2_dxji_r;
  logic signed [C+1:0] s2_dxi_r;
  logic signed [C:0]   s2_dy_r;
  logic               s3_v_r;
  logic               s3_dypos_r;
  logic signed [PW-1:0] lhs_r;
  logic signed [PW-1:0] rhs_r;
  logic               crossing;
  logic               parity_r;

  // Handshake and sequencing
  assign out_free   = !out_valid_r || out_ready;
  assign q_ready    = (state_r == ST_IDLE) && out_free;
  assign pop        = q_valid && q_ready;
  assign start_walk = pop && (q_op == pip_pkg::OP_QUERY) && (count_r != '0);
  assign cnt_m1     = count_r - CW'(1);
  assign last_idx   = cnt_m1[AW-1:0];
  assign raddr      = (state_r == ST_WALK) ? k_r : last_idx;
  assign rd_en      = start_walk || (state_r == ST_WALK);
  assign pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;
  assign we         = pop && (q_op == pip_pkg::OP_APPEND) && (count_r < MAX_CNT);
  assign waddr      = count_r[AW-1:0];

  // Write appended vertices, read one vertex per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= q_x[C-1:0];
      mem_y[waddr] <= q_y[C-1:0];
    end
    mem_qx <= mem_x[raddr];
    mem_qy <= mem_y[raddr];
  end

  // Edge setup: current vertex from memory, previous vertex held
  assign xi_e = {{2{mem_qx[C-1]}}, mem_qx};
  assign yi_e = {{2{mem_qy[C-1]}}, mem_qy};
  assign xj_e = {{2{prev_x_r[C-1]}}, prev_x_r};
  assign yj_e = {{2{prev_y_r[C-1]}}, prev_y_r};
  assign px_e = {px_r[C], px_r};
  assign py_e = {py_r[C], py_r};

  assign straddle  = ((yi_e < py_e) && (yj_e >= py_e)) || ((yj_e < py_e) && (yi_e >= py_e));
  assign leftish   = (xi_e <= px_e) || (xj_e <= px_e);
  assign dy_full   = yj_e - yi_e;
  assign dxji_full = xj_e - xi_e;
  assign dyi       = py_e - yi_e;
  assign dxi       = px_e - xi_e;

  // Compare the cross products, direction set by the sign of dy
  assign crossing = s3_dypos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r);

  // Edge pipeline: setup, multiply, compare and toggle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r && !s1_first_r && straddle && leftish;
      s3_v_r <= s2_v_r;
    end
    s1_first_r <= start_walk;
    if (s1_v_r) begin
      prev_x_r <= mem_qx;
      prev_y_r <= mem_qy;
    end
    s2_dyi_r   <= dyi;
    s2_dxji_r  <= dxji_full[C:0];
    s2_dxi_r   <= dxi;
    s2_dy_r    <= dy_full[C:0];
    lhs_r      <= s2_dyi_r * s2_dxji_r;
    rhs_r      <= s2_dxi_r * s2_dy_r;
    s3_dypos_r <= (s2_dy_r > 0);
    if (start_walk) begin
      parity_r <= 1'b0;
    end else if (s3_v_r && crossing) begin
      parity_r <= !parity_r;
    end
  end

  // Sequencer: state, vertex count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            unique case (q_op)
              pip_pkg::OP_APPEND: begin
                out_valid_r <= 1'b1;
                inside_r    <= 1'b0;
                if (count_r < MAX_CNT) begin
                  count_r  <= count_r + CW'(1);
                  status_r <= 1'b0;
                end else begin
                  status_r <= 1'b1;
                end
              end
              pip_pkg::OP_QUERY: begin
                if (count_r == '0) begin
                  out_valid_r <= 1'b1;
                  inside_r    <= 1'b0;
                  status_r    <= 1'b0;
                end else begin
                  px_r    <= q_x;
                  py_r    <= q_y;
                  k_r     <= '0;
                  state_r <= ST_WALK;
                end
              end
              pip_pkg::OP_CLEAR: begin
                count_r     <= '0;
                out_valid_r <= 1'b1;
                inside_r    <= 1'b0;
                status_r    <= 1'b0;
              end
              default: begin
                out_valid_r <= 1'b1;
                inside_r    <= 1'b0;
                status_r    <= 1'b0;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (k_r == last_idx) begin
            state_r <= ST_DRAIN;
          end else begin
            k_r <= k_r + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_empty && out_free) begin
            out_valid_r <= 1'b1;
            inside_r    <= parity_r;
            status_r    <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;
  assign out_status     = status_r;

endmodule

// ===== sv/point_in_polygon_test.sv =====
// Even-odd point-in-polygon block: front end, item queue and edge walker.
// Append, clear and unused commands: one result each; one item per cycle while out_ready is high and no walk runs.
// Query: the edge walker reads the N stored vertices through the single vertex-store read
// port, visiting one vertex per cycle (N + 1 reads), then drains the edge pipeline into
// the result register; one query walked at a time.
// Reset (rst_n low, synchronous): empties queue and polygon; store contents are kept.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  input  logic [COORD_BITS-1:0] in_offset_x,
  input  logic [COORD_BITS-1:0] in_offset_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_inside_res,
  output logic                  out_status
);

  localparam int QW = pip_pkg::OP_BITS + 2 * (COORD_BITS + 1);

  logic                  f_valid;
  logic                  f_ready;
  pip_pkg::op_t          f_op;
  logic [COORD_BITS:0]   f_x;
  logic [COORD_BITS:0]   f_y;
  logic [QW-1:0]         push_data;
  logic [QW-1:0]         pop_data;
  logic                  b_valid;
  logic                  b_ready;
  pip_pkg::op_t          b_op;
  logic [COORD_BITS:0]   b_x;
  logic [COORD_BITS:0]   b_y;

  pip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_coord_x  (in_coord_x),
    .in_coord_y  (in_coord_y),
    .in_offset_x (in_offset_x),
    .in_offset_y (in_offset_y),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_op        (f_op),
    .q_x         (f_x),
    .q_y         (f_y)
  );

  // Pack and unpack queue entries
  assign push_data = {f_op, f_x, f_y};
  assign b_op      = pip_pkg::op_t'(pop_data[QW-1 -: pip_pkg::OP_BITS]);
  assign b_x       = pop_data[2*COORD_BITS+1 -: COORD_BITS+1];
  assign b_y       = pop_data[COORD_BITS:0];

  pip_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (push_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (pop_data)
  );

  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (b_valid),
    .q_ready        (b_ready),
    .q_op           (b_op),
    .q_x            (b_x),
    .q_y            (b_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .out_status     (out_status)
  );

endmodule
